// ----- design/stbs_pkg.sv -----
// Shared types and constants for the sorted table with binary search.
package stbs_pkg;

	localparam int TABLE_DEPTH = 256;
	localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int VAL_W       = 32;
	localparam int OUT_CNT_W   = 9;

	typedef enum logic [1:0] {
		CMD_CLEAR  = 2'd0,
		CMD_INSERT = 2'd1,
		CMD_SEARCH = 2'd2
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INS_RD,
		ST_INS_CMP,
		ST_SRCH_RD,
		ST_SRCH_CMP,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic                 found;
		logic                 full_error;
		logic [OUT_CNT_W-1:0] entry_count;
	} result_t;

endpackage

// ----- design/stbs_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
module stbs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                                         clk,
	input  logic                                         we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                             wdata,
	input  logic                                         re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                             rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- design/stbs_engine.sv -----
// Command sequencer: clear, sorted insert by shifting, and binary search over the table RAM.
module stbs_engine import stbs_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [1:0]              command,
	input  logic signed [VAL_W-1:0] value,
	output logic                    ram_we,
	output logic [ADDR_W-1:0]       ram_waddr,
	output logic [VAL_W-1:0]        ram_wdata,
	output logic                    ram_re,
	output logic [ADDR_W-1:0]       ram_raddr,
	input  logic [VAL_W-1:0]        ram_rdata,
	output logic                    res_valid,
	input  logic                    res_ready,
	output result_t                 res
);

	state_t                  state_q, state_d;
	logic [CNT_W-1:0]        cnt_q;
	logic [CNT_W-1:0]        slot_q;
	logic [CNT_W-1:0]        lo_q;
	logic [CNT_W-1:0]        hie_q;
	logic [CNT_W-1:0]        mid_q;
	logic signed [VAL_W-1:0] val_q;
	logic                    found_q;
	logic                    ferr_q;

	logic                    accept;
	logic                    table_full;
	logic                    probe_gt;
	logic                    probe_eq;
	logic [CNT_W:0]          mid_sum;
	logic [CNT_W-1:0]        mid;
	logic [CNT_W-1:0]        slot_m1;

	assign accept     = in_valid && in_ready;
	assign table_full = (cnt_q == CNT_W'(TABLE_DEPTH));
	assign probe_gt   = $signed(ram_rdata) > val_q;
	assign probe_eq   = $signed(ram_rdata) == val_q;
	assign mid_sum    = {1'b0, lo_q} + {1'b0, hie_q} - (CNT_W+1)'(1);
	assign mid        = mid_sum[CNT_W:1];
	assign slot_m1    = slot_q - CNT_W'(1);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (command)
						CMD_INSERT: state_d = table_full ? ST_DONE : ST_INS_RD;
						CMD_SEARCH: state_d = ST_SRCH_RD;
						default:    state_d = ST_DONE;
					endcase
				end
			end
			ST_INS_RD:   state_d = (slot_q == '0) ? ST_DONE : ST_INS_CMP;
			ST_INS_CMP:  state_d = probe_gt ? ST_INS_RD : ST_DONE;
			ST_SRCH_RD:  state_d = (lo_q >= hie_q) ? ST_DONE : ST_SRCH_CMP;
			ST_SRCH_CMP: state_d = probe_eq ? ST_DONE : ST_SRCH_RD;
			ST_DONE:     state_d = res_ready ? ST_IDLE : ST_DONE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// outputs: handshake, RAM port controls, result
	always_comb begin
		in_ready  = 1'b0;
		res_valid = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = slot_q[ADDR_W-1:0];
		ram_wdata = val_q;
		ram_re    = 1'b0;
		ram_raddr = slot_m1[ADDR_W-1:0];
		case (state_q)
			ST_IDLE: in_ready = 1'b1;
			ST_INS_RD: begin
				if (slot_q == '0) begin
					ram_we = 1'b1;
				end else begin
					ram_re = 1'b1;
				end
			end
			ST_INS_CMP: begin
				ram_we = 1'b1;
				if (probe_gt) begin
					ram_wdata = ram_rdata;
				end
			end
			ST_SRCH_RD: begin
				ram_re    = (lo_q < hie_q);
				ram_raddr = mid[ADDR_W-1:0];
			end
			ST_DONE: res_valid = 1'b1;
			default: ;
		endcase
		res.found       = found_q;
		res.full_error  = ferr_q;
		res.entry_count = OUT_CNT_W'(cnt_q);
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE && accept && command == CMD_CLEAR) begin
				cnt_q <= '0;
			end else if ((state_q == ST_INS_RD && slot_q == '0) ||
			             (state_q == ST_INS_CMP && !probe_gt)) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	// datapath: latch the beat, step the shift slot and the search bounds
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					val_q   <= value;
					slot_q  <= cnt_q;
					lo_q    <= '0;
					hie_q   <= cnt_q;
					found_q <= 1'b0;
					ferr_q  <= (command == CMD_INSERT) && table_full;
				end
			end
			ST_INS_CMP: begin
				if (probe_gt) begin
					slot_q <= slot_m1;
				end
			end
			ST_SRCH_RD: mid_q <= mid;
			ST_SRCH_CMP: begin
				if (probe_eq) begin
					found_q <= 1'b1;
				end else if (probe_gt) begin
					hie_q <= mid_q;
				end else begin
					lo_q <= mid_q + CNT_W'(1);
				end
			end
			default: ;
		endcase
	end

endmodule

// ----- design/stbs_out_reg.sv -----
// Output register that holds a result beat until the consumer takes it.
module stbs_out_reg import stbs_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 res_valid,
	output logic                 res_ready,
	input  result_t              res,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 found,
	output logic                 full_error,
	output logic [OUT_CNT_W-1:0] entry_count
);

	logic    valid_q;
	result_t data_q;

	assign res_ready   = !valid_q || out_ready;
	assign out_valid   = valid_q;
	assign found       = data_q.found;
	assign full_error  = data_q.full_error;
	assign entry_count = data_q.entry_count;

	// hold the beat until taken, load a new one when the slot frees
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res_ready) begin
			valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			data_q <= res;
		end
	end

endmodule

// ----- design/sorted_table_binary_search_top.sv -----
// Clear, an unused code and a refused insert go straight to the result.
// Insert: each larger entry is read and moved up one slot, then the value is written in the free slot.
// Search: binary probes at the midpoint of the bounds until a hit or until the bounds meet.
// One command at a time: the next is taken once the result has passed to the output register;
// each probe or shift is a read then a compare through the single table RAM.
// Reset clears the count and control state; table contents stay undefined, never read unwritten.
module sorted_table_binary_search_top import stbs_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [1:0]              command,
	input  logic signed [VAL_W-1:0] value,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic                    found,
	output logic                    full_error,
	output logic [OUT_CNT_W-1:0]    entry_count
);

	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [VAL_W-1:0]  ram_wdata;
	logic              ram_re;
	logic [ADDR_W-1:0] ram_raddr;
	logic [VAL_W-1:0]  ram_rdata;
	logic              res_valid;
	logic              res_ready;
	result_t           res;

	// table storage
	stbs_ram #(
		.WIDTH (VAL_W),
		.DEPTH (TABLE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// command sequencer
	stbs_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.command   (command),
		.value     (value),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// result register
	stbs_out_reg u_out_reg (
		.clk         (clk),
		.arst_n      (arst_n),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res         (res),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.found       (found),
		.full_error  (full_error),
		.entry_count (entry_count)
	);

endmodule

// ----- design/stbs_checker.sv -----
// Port-level checks for the sorted table top level, attached by bind.
module stbs_checker import stbs_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_ready,
	input logic [1:0]              command,
	input logic signed [VAL_W-1:0] value,
	input logic                    out_valid,
	input logic                    out_ready,
	input logic                    found,
	input logic                    full_error,
	input logic [OUT_CNT_W-1:0]    entry_count
);

	// a stalled result beat stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result beat dropped while stalled");

	// a result never flags both a hit and a refused insert
	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(found && full_error))
		else $error("found and full_error both set");

	// count never exceeds the table depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (32'(entry_count) <= TABLE_DEPTH))
		else $error("entry_count above table depth");

	// the block is busy in the cycle after it takes a command
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("command taken while previous one still in progress");

endmodule

bind sorted_table_binary_search_top stbs_checker u_checker (.*);

// ----- tb/sv/testbench.sv -----
// Testbench for the sorted table: directed and random command streams checked by a local predictor.
`timescale 1ns / 1ps

module testbench;
	import stbs_pkg::*;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS    = 110;
	localparam int CALM_ITEMS      = 30;
	localparam int DRAIN_CYCLES    = 2 * TABLE_DEPTH + 16;

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    in_valid;
	logic                    in_ready;
	logic [1:0]              command;
	logic signed [VAL_W-1:0] value;
	logic                    out_valid;
	logic                    out_ready;
	logic                    found;
	logic                    full_error;
	logic [OUT_CNT_W-1:0]    entry_count;

	// Predictor state: sorted copy of the table and its fill level
	logic signed [VAL_W-1:0] held_vals [TABLE_DEPTH];
	int                      held_count = 0;

	result_t     pending_results [$];
	int          error_count = 0;
	bit          idle_on = 1'b1;
	int unsigned stall_left = 0;

	sorted_table_binary_search_top DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.command    (command),
		.value      (value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.found      (found),
		.full_error (full_error),
		.entry_count(entry_count)
	);

	always #4 clk = ~clk;

	// Apply one command to the local table and return the response it causes
	function automatic result_t apply_table_command(input logic [1:0] cmd,
			input logic signed [VAL_W-1:0] val);
		result_t res;
		int      pos;
		int      lo;
		int      hi;
		int      mid;
		res = '0;
		case (cmd)
			CMD_CLEAR: begin
				held_count = 0;
			end
			CMD_INSERT: begin
				if (held_count >= TABLE_DEPTH) begin
					res.full_error = 1'b1;
				end else begin
					// place after equal values, shifting larger ones up
					pos = held_count;
					while (pos > 0 && held_vals[pos-1] > val) begin
						held_vals[pos] = held_vals[pos-1];
						pos--;
					end
					held_vals[pos] = val;
					held_count++;
				end
			end
			CMD_SEARCH: begin
				lo = 0;
				hi = held_count - 1;
				while (lo <= hi && !res.found) begin
					mid = (lo + hi) / 2;
					if (held_vals[mid] == val)
						res.found = 1'b1;
					else if (held_vals[mid] > val)
						hi = mid - 1;
					else
						lo = mid + 1;
				end
			end
			default: ;
		endcase
		res.entry_count = OUT_CNT_W'(held_count);
		return res;
	endfunction

	// Send one beat, with an optional gap, and record its response on accept
	task automatic send_command(input logic [1:0] cmd, input logic signed [VAL_W-1:0] val);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		in_valid <= 1'b1;
		command  <= cmd;
		value    <= val;
		do @(posedge clk); while (in_ready !== 1'b1);
		pending_results.insert(pending_results.size(), apply_table_command(cmd, val));
	endtask

	// Mix of extremes, small values that collide, and full-range values
	function automatic logic signed [VAL_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 3))
					0: return 32'sh8000_0000;
					1: return 32'sh7fff_ffff;
					2: return 32'sh0000_0000;
					default: return 32'shffff_ffff;
				endcase
			end
			1, 2, 3: return $signed($urandom_range(0, 8)) - 4;
			default: return $urandom;
		endcase
	endfunction

	// Mostly keys that are held or adjacent to held ones
	function automatic logic signed [VAL_W-1:0] pick_key();
		logic signed [VAL_W-1:0] k;
		if (held_count > 0 && $urandom_range(0, 9) < 7) begin
			k = held_vals[$urandom_range(0, held_count - 1)];
			case ($urandom_range(0, 3))
				0: k = k + 1;
				1: k = k - 1;
				default: ;
			endcase
			return k;
		end
		return pick_value();
	endfunction

	task automatic test_empty_table();
		send_command(CMD_SEARCH, 32'sh0000_0000);
		send_command(CMD_CLEAR, 32'sh1234_5678);
		send_command(CMD_SEARCH, 32'sh8000_0000);
	endtask

	task automatic test_value_extremes();
		send_command(CMD_INSERT, 32'sh7fff_ffff);
		send_command(CMD_INSERT, 32'sh8000_0000);
		send_command(CMD_INSERT, 32'sh0000_0000);
		send_command(CMD_INSERT, 32'shffff_ffff);
		send_command(CMD_INSERT, 32'sh0000_0001);
		send_command(CMD_SEARCH, 32'sh8000_0000);
		send_command(CMD_SEARCH, 32'sh7fff_ffff);
		send_command(CMD_SEARCH, 32'sh0000_0000);
		send_command(CMD_SEARCH, 32'sh8000_0001);
		send_command(CMD_SEARCH, 32'sh7fff_fffe);
		send_command(CMD_SEARCH, 32'sh0000_0005);
	endtask

	task automatic test_duplicates();
		send_command(CMD_INSERT, 32'sh0000_0007);
		send_command(CMD_INSERT, 32'sh0000_0007);
		send_command(CMD_INSERT, 32'sh0000_0007);
		send_command(CMD_SEARCH, 32'sh0000_0007);
		send_command(CMD_SEARCH, 32'sh0000_0006);
		send_command(CMD_SEARCH, 32'sh0000_0008);
	endtask

	task automatic test_unused_code();
		send_command(CMD_UNUSED, 32'sh0000_0007);
		send_command(CMD_UNUSED, 32'shffff_ffff);
		send_command(CMD_CLEAR, 32'sh0000_0000);
		send_command(CMD_UNUSED, 32'sh8000_0000);
	endtask

	task automatic test_full_table();
		logic signed [VAL_W-1:0] v;
		int                      i;
		send_command(CMD_CLEAR, 32'sh0000_0000);
		// descending values force the longest shifts, zero steps give copies
		v = 32'sh7000_0000;
		for (i = 0; i < TABLE_DEPTH; i++) begin
			send_command(CMD_INSERT, v);
			v = v - $signed($urandom_range(0, 3));
		end
		send_command(CMD_INSERT, 32'sh7fff_ffff);
		send_command(CMD_INSERT, 32'sh8000_0000);
		send_command(CMD_SEARCH, 32'sh7000_0000);
		send_command(CMD_SEARCH, v);
		send_command(CMD_SEARCH, 32'sh7fff_ffff);
		send_command(CMD_UNUSED, 32'sh0000_0000);
		send_command(CMD_CLEAR, 32'sh0000_0000);
		send_command(CMD_SEARCH, 32'sh7000_0000);
	endtask

	task automatic test_random_traffic();
		int sent;
		int fills;
		int probes;
		int i;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			// drop idling for the tail of the run
			if (sent >= RANDOM_ITEMS - CALM_ITEMS)
				idle_on = 1'b0;
			if ($urandom_range(0, 2) == 0) begin
				send_command(CMD_CLEAR, $urandom);
				sent++;
			end
			fills = ($urandom_range(0, 11) == 0) ? $urandom_range(40, 140)
				: $urandom_range(0, 20);
			probes = $urandom_range(1, 12);
			for (i = 0; i < fills; i++) begin
				send_command(CMD_INSERT, pick_value());
				sent++;
			end
			for (i = 0; i < probes; i++) begin
				// sprinkle noise among the lookups
				case ($urandom_range(0, 15))
					0: send_command(CMD_UNUSED, $urandom);
					1: begin
						send_command(CMD_INSERT, pick_value());
						sent++;
					end
					default: begin
						send_command(CMD_SEARCH, pick_key());
						sent++;
					end
				endcase
			end
		end
	endtask

	// Stall the result side in random bursts
	always @(posedge clk) begin
		if (stall_left != 0) begin
			out_ready  <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			out_ready  <= 1'b0;
			stall_left <= $urandom_range(0, 8);
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Compare each result beat with the oldest pending response
	always @(posedge clk) begin
		result_t want;
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result beat: found=%0b full_error=%0b entry_count=%0d",
					found, full_error, entry_count);
				error_count++;
			end else begin
				want = pending_results.pop_front();
				if (found !== want.found) begin
					$error("found: expected %0b, got %0b", want.found, found);
					error_count++;
				end
				if (full_error !== want.full_error) begin
					$error("full_error: expected %0b, got %0b", want.full_error, full_error);
					error_count++;
				end
				if (entry_count !== want.entry_count) begin
					$error("entry_count: expected %0d, got %0d", want.entry_count, entry_count);
					error_count++;
				end
			end
		end
	end

	initial begin
		#20_000_000;
		$display("FAILURE");
		$finish;
	end

	initial begin
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		command   <= CMD_CLEAR;
		value     <= '0;
		out_ready <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_table();
		test_value_extremes();
		test_duplicates();
		test_unused_code();
		test_full_table();
		test_random_traffic();

		// release the input and drain what is still in flight
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0 && pending_results.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
